FILE: sv/fraction_add_multiply_reduce_unit_defines.svh
// Assertion macros shared by the fraction unit modules.
// Needs no other file.
`ifndef FRACTION_ADD_MULTIPLY_REDUCE_UNIT_DEFINES_SVH
`define FRACTION_ADD_MULTIPLY_REDUCE_UNIT_DEFINES_SVH

// Checks that a condition implies a consequence at the same edge.
`define FAMR_ASSERT_IMP(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");

// Checks that a condition implies a consequence at the next edge.
`define FAMR_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/famr_pkg.sv
// Package for the fraction unit: opcodes and controller command/status types.
// Needs no other file.
package famr_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_MUL = 2'd1;
  localparam logic [1:0] OP_CMP = 2'd2;

  typedef struct packed {
    logic load;      // capture operands
    logic products;  // register the three products
    logic combine;   // form numerator and denominator
    logic gcd_step;  // one subtract/shift step of the GCD
    logic div_init;  // set up the divisions by the GCD
    logic div_step;  // one restoring division step on both quotients
    logic finish;    // present the result
  } famr_cmd_t;

  typedef struct packed {
    logic reduce;    // numerator and denominator both positive, no error, add or multiply
    logic gcd_done;
    logic div_done;
  } famr_sts_t;

endpackage

FILE: sv/famr_ctrl.sv
// Controller state machine for the fraction unit.
// Depends on famr_pkg.
`include "fraction_add_multiply_reduce_unit_defines.svh"
module famr_ctrl import famr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  famr_sts_t sts,
  output famr_cmd_t cmd,
  output logic      busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PROD = 3'd1;
  localparam logic [2:0] S_COMB = 3'd2;
  localparam logic [2:0] S_TEST = 3'd3;
  localparam logic [2:0] S_GCD  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_PROD;
        end
      end
      S_PROD: begin
        cmd.products = 1'b1;
        state_next = S_COMB;
      end
      S_COMB: begin
        cmd.combine = 1'b1;
        state_next = S_TEST;
      end
      S_TEST: begin
        state_next = sts.reduce ? S_GCD : S_DONE;
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.div_init = 1'b1;
          state_next = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  `FAMR_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `FAMR_ASSERT_IMP(a_finish_once, clk, rst, cmd.finish, state == S_DONE)
  `FAMR_ASSERT_NEXT(a_done_idle, clk, rst, state == S_DONE, !busy)

endmodule

FILE: sv/famr_dp.sv
// Datapath for the fraction unit: products, binary GCD, and two
// restoring divisions by the GCD. Depends on famr_pkg.
`include "fraction_add_multiply_reduce_unit_defines.svh"
module famr_dp import famr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  famr_cmd_t          cmd,
  input  logic [1:0]         opcode,
  input  logic signed [15:0] a_num,
  input  logic signed [15:0] a_den,
  input  logic signed [15:0] b_num,
  input  logic signed [15:0] b_den,
  output famr_sts_t          sts,
  output logic signed [31:0] res_num,
  output logic signed [31:0] res_den,
  output logic               is_equal,
  output logic               div_error,
  output logic               done
);

  logic [1:0]         op;
  logic signed [15:0] an, ad, bn, bd;
  logic signed [31:0] p0, p1, p2;
  logic [31:0]        num, den;
  logic               err;
  logic [31:0]        gx, gy;
  logic [4:0]         gk;
  logic [31:0]        g;
  logic [31:0]        qn, qd;
  logic [31:0]        rn, rd;
  logic [5:0]         dcnt;
  logic [32:0]        tn, td;
  logic [31:0]        gsmall, gbig;

  assign sts.reduce   = num >= 32'd1 && !num[31] && den >= 32'd1 && !den[31]
                        && !err && (op == OP_ADD || op == OP_MUL);
  assign sts.gcd_done = (gx == '0) || (gy == '0);
  assign sts.div_done = (dcnt == 6'd32);

  assign gsmall = (gx < gy) ? gx : gy;
  assign gbig   = (gx < gy) ? gy : gx;
  assign tn = {rn, qn[31]} - {1'b0, g};
  assign td = {rd, qd[31]} - {1'b0, g};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= opcode;
      an <= a_num;
      ad <= a_den;
      bn <= b_num;
      bd <= b_den;
    end
    if (cmd.products) begin
      // Add needs an*bd + bn*ad; multiply needs an*bn.
      p0 <= (op == OP_ADD) ? an * bd : an * bn;
      p1 <= bn * ad;
      p2 <= ad * bd;
    end
    if (cmd.combine) begin
      err <= (op == OP_ADD) && (ad == '0 || bd == '0);
      num <= (op == OP_ADD) ? 32'(p0 + p1) : 32'(p0);
      den <= 32'(p2);
      gk  <= '0;
    end
    if (cmd.combine) begin
      gx <= (op == OP_ADD) ? 32'(p0 + p1) : 32'(p0);
      gy <= 32'(p2);
    end
    // Binary GCD: strip common twos, then subtract the smaller odd value.
    if (cmd.gcd_step) begin
      if (!gx[0] && !gy[0]) begin
        gx <= gx >> 1;
        gy <= gy >> 1;
        gk <= gk + 5'd1;
      end else if (!gx[0]) begin
        gx <= gx >> 1;
      end else if (!gy[0]) begin
        gy <= gy >> 1;
      end else begin
        gx <= gsmall;
        gy <= gbig - gsmall;
      end
    end
    if (cmd.div_init) begin
      g    <= (gx | gy) << gk;
      qn   <= num;
      qd   <= den;
      rn   <= '0;
      rd   <= '0;
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      if (!tn[32]) begin
        rn <= tn[31:0];
        qn <= {qn[30:0], 1'b1};
      end else begin
        rn <= {rn[30:0], qn[31]};
        qn <= {qn[30:0], 1'b0};
      end
      if (!td[32]) begin
        rd <= td[31:0];
        qd <= {qd[30:0], 1'b1};
      end else begin
        rd <= {rd[30:0], qd[31]};
        qd <= {qd[30:0], 1'b0};
      end
      dcnt <= dcnt + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      is_equal  <= (op == OP_CMP) && an == bn && ad == bd;
      div_error <= err && (op == OP_ADD);
      if ((op == OP_ADD && !err) || op == OP_MUL) begin
        res_num <= sts.reduce ? qn : num;
        res_den <= sts.reduce ? qd : den;
      end else begin
        res_num <= '0;
        res_den <= '0;
      end
    end
  end

  `FAMR_ASSERT_IMP(a_div_bounded, clk, rst, cmd.div_step, dcnt < 6'd32)
  `FAMR_ASSERT_NEXT(a_gcd_nonzero, clk, rst, cmd.div_init, g != '0)
  `FAMR_ASSERT_NEXT(a_finish_done, clk, rst, cmd.finish, done)

endmodule

FILE: sv/fraction_add_multiply_reduce_unit.sv
// Top level of the fraction add / multiply / compare unit.
// Depends on famr_pkg, famr_ctrl and famr_dp.
//
//   channel   | handshake          | ports
//   ----------+--------------------+--------------------------------------
//   command   | start, busy        | opcode, a_num, a_den, b_num, b_den
//   result    | done (one cycle)   | res_num, res_den, is_equal, div_error
//
// A transaction is taken when start is high and busy is low. Compare, error
// and unreduced results skip the reduction. Reduced results add the binary
// GCD loop, a setup step and the two restoring dividers, which run side by
// side on numerator and denominator. Synchronous reset returns the
// controller to idle.
// The result strobe lasts one cycle and cannot be stalled.
module fraction_add_multiply_reduce_unit import famr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic signed [15:0] a_num,
  input  logic signed [15:0] a_den,
  input  logic signed [15:0] b_num,
  input  logic signed [15:0] b_den,
  output logic               done,
  output logic signed [31:0] res_num,
  output logic signed [31:0] res_den,
  output logic               is_equal,
  output logic               div_error
);

  famr_cmd_t cmd;
  famr_sts_t sts;

  famr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
  );

  famr_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .opcode(opcode),
    .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .sts(sts), .res_num(res_num), .res_den(res_den),
    .is_equal(is_equal), .div_error(div_error), .done(done)
  );

endmodule

FILE: verif/tb_fraction_add_multiply_reduce_unit.sv
// Testbench for the fraction add / multiply / compare unit with GCD reduction.
// Depends on famr_pkg and fraction_add_multiply_reduce_unit; predicts each result itself.
`timescale 1ns / 1ps

module tb_fraction_add_multiply_reduce_unit import famr_pkg::*;;

  typedef struct {
    logic signed [31:0] num;
    logic signed [31:0] den;
    logic               eq;
    logic               err;
  } fraction_result_t;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         opcode = OP_ADD;
  logic signed [15:0] a_num = '0;
  logic signed [15:0] a_den = '0;
  logic signed [15:0] b_num = '0;
  logic signed [15:0] b_den = '0;
  logic               done;
  logic signed [31:0] res_num;
  logic signed [31:0] res_den;
  logic               is_equal;
  logic               div_error;

  fraction_result_t expected_results[$];
  int unsigned      error_count = 0;
  int unsigned      cycle_count = 0;
  int unsigned      idle_percent = 0;

  always #1 clk = ~clk;

  fraction_add_multiply_reduce_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .done(done), .res_num(res_num), .res_den(res_den),
    .is_equal(is_equal), .div_error(div_error)
  );

  function automatic logic [31:0] gcd_of(logic [31:0] x, logic [31:0] y);
    logic [31:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic fraction_result_t reduced_fraction(logic [1:0] op,
      logic signed [15:0] an, logic signed [15:0] ad,
      logic signed [15:0] bn, logic signed [15:0] bd);
    fraction_result_t r;
    logic signed [63:0] wide;
    logic [31:0] n, d, g;
    n = '0;
    d = '0;
    r.eq = 1'b0;
    r.err = 1'b0;
    case (op)
      OP_ADD: begin
        if (ad == 0 || bd == 0) begin
          r.err = 1'b1;
        end else begin
          wide = 64'(an) * 64'(bd) + 64'(bn) * 64'(ad);
          n = wide[31:0];
          wide = 64'(ad) * 64'(bd);
          d = wide[31:0];
        end
      end
      OP_MUL: begin
        wide = 64'(an) * 64'(bn);
        n = wide[31:0];
        wide = 64'(ad) * 64'(bd);
        d = wide[31:0];
      end
      OP_CMP: r.eq = (an == bn) && (ad == bd);
      default: ;
    endcase
    // Reduce only when both parts are strictly positive as signed 32-bit values.
    if ((op == OP_ADD || op == OP_MUL) && !r.err && n != 0 && !n[31] && d != 0 && !d[31]) begin
      g = gcd_of(n, d);
      n = n / g;
      d = d / g;
    end
    r.num = n;
    r.den = d;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Each result strobe is compared against the oldest outstanding transaction.
  always @(posedge clk) begin
    fraction_result_t w;
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, queue depth", 0, 1);
      end else begin
        w = expected_results.pop_front();
        if (res_num !== w.num) report_mismatch("res_num", res_num, w.num);
        if (res_den !== w.den) report_mismatch("res_den", res_den, w.den);
        if (is_equal !== w.eq) report_mismatch("is_equal", is_equal, w.eq);
        if (div_error !== w.err) report_mismatch("div_error", div_error, w.err);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Start stays high after acceptance so that the next transaction can follow
  // in the same step; it drops only while the sender idles.
  task automatic send_fraction_op(logic [1:0] op, logic signed [15:0] an,
      logic signed [15:0] ad, logic signed [15:0] bn, logic signed [15:0] bd);
    while ($urandom_range(99) < idle_percent) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    opcode <= op;
    a_num  <= an;
    a_den  <= ad;
    b_num  <= bn;
    b_den  <= bd;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(reduced_fraction(op, an, ad, bn, bd));
  endtask

  function automatic logic signed [15:0] random_operand();
    case ($urandom_range(9))
      0: return 16'(-32768 + $urandom_range(1));
      1: return 16'(32767 - $urandom_range(1));
      2: return 16'($urandom_range(2)) - 16'sd1;
      3, 4: return 16'($urandom_range(40)) - 16'sd20;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed_cases();
    send_fraction_op(OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
    send_fraction_op(OP_ADD, 16'sd1, 16'sd4, 16'sd1, 16'sd4);
    send_fraction_op(OP_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd3);
    send_fraction_op(OP_ADD, 16'sd1, 16'sd3, 16'sd1, 16'sd0);
    send_fraction_op(OP_ADD, -16'sd1, 16'sd2, 16'sd1, 16'sd3);
    send_fraction_op(OP_ADD, 16'sd1, -16'sd2, 16'sd1, -16'sd2);
    send_fraction_op(OP_ADD, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_fraction_op(OP_ADD, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
    send_fraction_op(OP_ADD, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_fraction_op(OP_MUL, 16'sd6, 16'sd4, 16'sd2, 16'sd9);
    send_fraction_op(OP_MUL, 16'sd6, 16'sd0, 16'sd2, 16'sd9);
    send_fraction_op(OP_MUL, 16'sd0, 16'sd5, 16'sd3, 16'sd7);
    send_fraction_op(OP_MUL, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_fraction_op(OP_MUL, 16'sd32767, 16'sd1, 16'sd32767, 16'sd1);
    send_fraction_op(OP_MUL, 16'sd1, 16'sd1, 16'sd1, 16'sd1);
    send_fraction_op(OP_CMP, 16'sd3, 16'sd4, 16'sd3, 16'sd4);
    send_fraction_op(OP_CMP, 16'sd3, 16'sd4, 16'sd6, 16'sd8);
    send_fraction_op(OP_CMP, -16'sd1, 16'sd0, -16'sd1, 16'sd0);
    send_fraction_op(OP_NONE, 16'sd5, 16'sd6, 16'sd7, 16'sd8);
  endtask

  task automatic test_random_phase(int unsigned count, int unsigned pct);
    logic signed [15:0] an;
    logic signed [15:0] ad;
    idle_percent = pct;
    repeat (count) begin
      an = random_operand();
      ad = random_operand();
      // Some compares use matching fields so that equality is seen often.
      if ($urandom_range(3) == 0)
        send_fraction_op(OP_CMP, an, ad, an, ad);
      else
        send_fraction_op(2'($urandom_range(3)), an, ad, random_operand(), random_operand());
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_phase(340, 0);
    wait_for_results();
    test_random_phase(340, 46);
    test_random_phase(340, 26);
    test_random_phase(340, 0);
    wait_for_results();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/famr_pkg.sv
sv/famr_ctrl.sv
sv/famr_dp.sv
sv/fraction_add_multiply_reduce_unit.sv
verif/tb_fraction_add_multiply_reduce_unit.sv
